// ===== rtl/mvp_pkg.sv =====
// shared types, constants and saturation helpers for the motor velocity pid block
// used by motor_velocity_pid and mvp_mac; depends on nothing

package mvp_pkg;

	localparam int unsigned GAIN_W      = 16;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CPR_DEFAULT = 517;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd1280;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd256;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd0;

	// direction codes
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	// 60e6 counts-to-rpm factor, split for the 18-bit multiplier port
	localparam int unsigned SPEED_K  = 60000000;
	localparam int unsigned SPD_LO   = SPEED_K % (2 ** 17);
	localparam int unsigned SPD_HI   = SPEED_K / (2 ** 17);

	// iir coefficients, q0.16
	localparam int unsigned COEF_POLE = 55968;
	localparam int unsigned COEF_ZERO = 4771;

	// dividend is the 57-bit product followed by 12 zero bits
	localparam int unsigned DIV_STEPS = 69;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic signed [63:0] ITERM_LIM = 64'sh1000_0000_0000_0000;

	typedef enum logic [1:0] {
		SH_0,
		SH_17,
		SH_24
	} mac_shift_t;

	typedef struct packed {
		logic               vld;
		logic               clr;
		mac_shift_t         sh;
		logic signed [17:0] a;
		logic signed [33:0] b;
	} mac_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DEN,
		S_DEN_W,
		S_NUM0,
		S_NUM1,
		S_NUM_W,
		S_DIV_LD,
		S_DIV,
		S_RAW,
		S_FLT0,
		S_FLT1,
		S_FLT2,
		S_FLT_W,
		S_SPEED,
		S_ERR,
		S_ESUM,
		S_I0,
		S_I1,
		S_I_W,
		S_ITERM,
		S_PD1,
		S_PD_W,
		S_U,
		S_OUT
	} mvp_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end else begin
			return x[31:0];
		end
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
		if (x > 64'sd140737488355327) begin
			return 48'sh7fff_ffff_ffff;
		end else if (x < -64'sd140737488355328) begin
			return 48'sh8000_0000_0000;
		end else begin
			return x[47:0];
		end
	endfunction

endpackage

// ===== rtl/mvp_if.sv =====
// valid/ready channel interfaces for the tick requests and the controller results
// standalone; widths follow the block's field list

interface mvp_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] encoder_count;
	logic        [31:0] timestamp_us;
	logic signed [31:0] target_rpm;

	modport source(output valid, output encoder_count, output timestamp_us,
		output target_rpm, input ready);
	modport sink(input valid, input encoder_count, input timestamp_us,
		input target_rpm, output ready);
endinterface

interface mvp_out_if;
	logic               valid;
	logic               ready;
	logic        [7:0]  duty;
	logic        [1:0]  direction;
	logic signed [31:0] speed_rpm;

	modport source(output valid, output duty, output direction, output speed_rpm,
		input ready);
	modport sink(input valid, input duty, input direction, input speed_rpm,
		output ready);
endinterface

// ===== rtl/motor_velocity_pid.sv =====
// motor velocity pid: the sequencer carries a tick request through to result valid,
// skipping the divide when the timestamp has not moved; the 69-step restoring divider
// sets the long path and one shared multiply-accumulate unit serves every product
// under the sequencer. a new tick is taken the cycle after the result register loads,
// even while the result still waits.
// arst_n clears gains to their defaults and all loop state to zero.

module motor_velocity_pid #(
	parameter int unsigned COUNTS_PER_REV = mvp_pkg::CPR_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	mvp_in_if.sink                             tick,
	mvp_out_if.source                          result,
	input  logic                               cfg_we,
	input  logic [mvp_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [mvp_pkg::GAIN_W-1:0]         cfg_data
);
	import mvp_pkg::*;

	localparam int unsigned CprMod = COUNTS_PER_REV % 65536;
	localparam logic signed [17:0] CprOp = (CprMod == 0) ? 18'sd1 : 18'(CprMod);

	mvp_state_t state_q, state_d;
	mac_op_t    mac_op;
	logic signed [63:0] acc;

	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;

	logic        [31:0] last_count_q, last_time_q;
	logic signed [31:0] last_raw_q, smoothed_q, last_err_q;
	logic signed [47:0] esum_q;

	logic        [31:0] dt_q, mag_q;
	logic               neg_q;
	logic signed [31:0] target_q;
	logic        [47:0] den_q;
	logic [DIV_STEPS-1:0] num_q;
	logic        [47:0] rem_q;
	logic        [31:0] q_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic signed [31:0] raw_q, speed_q, err_q;
	logic signed [32:0] diff_q;
	logic signed [63:0] iterm_q, u_q;

	logic               out_vld_q;
	logic        [7:0]  duty_q;
	logic        [1:0]  dir_q;
	logic signed [31:0] spd_out_q;

	logic               accept;
	logic               load_out;
	logic        [31:0] dcount;
	logic        [48:0] rem_sh;
	logic               rem_ge;
	logic        [32:0] q_sh;
	logic signed [31:0] speed_new;
	logic signed [63:0] u_abs;

	mvp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	assign tick.ready = (state_q == S_IDLE);
	assign accept     = tick.valid && tick.ready;
	assign load_out   = (state_q == S_OUT) && (!out_vld_q || result.ready);

	assign dcount    = tick.encoder_count - last_count_q;
	assign rem_sh    = {rem_q, num_q[DIV_STEPS-1]};
	assign rem_ge    = rem_sh >= {1'b0, den_q};
	assign q_sh      = {q_q, rem_ge};
	assign speed_new = sat32((acc + 64'sd32768) >>> 16);
	assign u_abs     = u_q[63] ? -u_q : u_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (accept) state_d = S_DEN;
			S_DEN:    state_d = (dt_q == 32'd0) ? S_FLT0 : S_DEN_W;
			S_DEN_W:  state_d = S_NUM0;
			S_NUM0:   state_d = S_NUM1;
			S_NUM1:   state_d = S_NUM_W;
			S_NUM_W:  state_d = S_DIV_LD;
			S_DIV_LD: state_d = S_DIV;
			S_DIV:    if (div_cnt_q == '0) state_d = S_RAW;
			S_RAW:    state_d = S_FLT0;
			S_FLT0:   state_d = S_FLT1;
			S_FLT1:   state_d = S_FLT2;
			S_FLT2:   state_d = S_FLT_W;
			S_FLT_W:  state_d = S_SPEED;
			S_SPEED:  state_d = S_ERR;
			S_ERR:    state_d = S_ESUM;
			S_ESUM:   state_d = S_I0;
			S_I0:     state_d = S_I1;
			S_I1:     state_d = S_I_W;
			S_I_W:    state_d = S_ITERM;
			S_ITERM:  state_d = S_PD1;
			S_PD1:    state_d = S_PD_W;
			S_PD_W:   state_d = S_U;
			S_U:      state_d = S_OUT;
			S_OUT:    if (load_out) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// operations issued to the shared unit
	always_comb begin
		mac_op = '0;
		case (state_q)
			S_DEN: begin
				mac_op.vld = (dt_q != 32'd0);
				mac_op.clr = 1'b1;
				mac_op.sh  = SH_0;
				mac_op.a   = CprOp;
				mac_op.b   = {2'b00, dt_q};
			end
			S_NUM0: begin
				mac_op.vld = 1'b1;
				mac_op.clr = 1'b1;
				mac_op.sh  = SH_0;
				mac_op.a   = 18'(SPD_LO);
				mac_op.b   = {2'b00, mag_q};
			end
			S_NUM1: begin
				mac_op.vld = 1'b1;
				mac_op.sh  = SH_17;
				mac_op.a   = 18'(SPD_HI);
				mac_op.b   = {2'b00, mag_q};
			end
			S_FLT0: begin
				mac_op.vld = 1'b1;
				mac_op.clr = 1'b1;
				mac_op.sh  = SH_0;
				mac_op.a   = 18'(COEF_POLE);
				mac_op.b   = 34'(smoothed_q);
			end
			S_FLT1: begin
				mac_op.vld = 1'b1;
				mac_op.sh  = SH_0;
				mac_op.a   = 18'(COEF_ZERO);
				mac_op.b   = 34'(raw_q);
			end
			S_FLT2: begin
				mac_op.vld = 1'b1;
				mac_op.sh  = SH_0;
				mac_op.a   = 18'(COEF_ZERO);
				mac_op.b   = 34'(last_raw_q);
			end
			S_I0: begin
				mac_op.vld = 1'b1;
				mac_op.clr = 1'b1;
				mac_op.sh  = SH_0;
				mac_op.a   = {2'b00, gain_i_q};
				mac_op.b   = {10'd0, esum_q[23:0]};
			end
			S_I1: begin
				mac_op.vld = 1'b1;
				mac_op.sh  = SH_24;
				mac_op.a   = {2'b00, gain_i_q};
				mac_op.b   = 34'($signed(esum_q[47:24]));
			end
			S_ITERM: begin
				mac_op.vld = 1'b1;
				mac_op.clr = 1'b1;
				mac_op.sh  = SH_0;
				mac_op.a   = {2'b00, gain_p_q};
				mac_op.b   = 34'(err_q);
			end
			S_PD1: begin
				mac_op.vld = 1'b1;
				mac_op.sh  = SH_0;
				mac_op.a   = {2'b00, gain_d_q};
				mac_op.b   = 34'(diff_q);
			end
			default: mac_op = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_P_RST;
			gain_i_q <= GAIN_I_RST;
			gain_d_q <= GAIN_D_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_GAIN_P: gain_p_q <= cfg_data;
				CFG_GAIN_I: gain_i_q <= cfg_data;
				CFG_GAIN_D: gain_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
			last_time_q  <= '0;
			last_raw_q   <= '0;
			smoothed_q   <= '0;
			esum_q       <= '0;
			last_err_q   <= '0;
			out_vld_q    <= 1'b0;
			div_cnt_q    <= '0;
		end else begin
			if (accept) begin
				last_count_q <= tick.encoder_count;
				last_time_q  <= tick.timestamp_us;
			end
			if (state_q == S_SPEED) begin
				smoothed_q <= speed_new;
				last_raw_q <= raw_q;
			end
			if (state_q == S_ESUM) begin
				esum_q     <= sat48(64'(esum_q) + 64'(err_q));
				last_err_q <= err_q;
			end
			if (state_q == S_DIV_LD) begin
				div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q     <= tick.timestamp_us - last_time_q;
			neg_q    <= dcount[31];
			mag_q    <= dcount[31] ? -dcount : dcount;
			target_q <= tick.target_rpm;
		end
		// zero time change keeps the previous raw speed
		if (state_q == S_DEN && dt_q == 32'd0) begin
			raw_q <= last_raw_q;
		end
		if (state_q == S_NUM0) begin
			den_q <= acc[47:0];
		end
		if (state_q == S_DIV_LD) begin
			num_q <= {acc[56:0], 12'd0};
			rem_q <= '0;
			q_q   <= '0;
		end
		if (state_q == S_DIV) begin
			num_q <= num_q << 1;
			rem_q <= rem_ge ? 48'(rem_sh - {1'b0, den_q}) : rem_sh[47:0];
			// quotient pinned at 2^31, past the signed range anyway
			q_q   <= (q_sh > 33'h0_8000_0000) ? 32'h8000_0000 : q_sh[31:0];
		end
		if (state_q == S_RAW) begin
			if (neg_q) begin
				raw_q <= -q_q;
			end else if (q_q[31]) begin
				raw_q <= 32'sh7fff_ffff;
			end else begin
				raw_q <= q_q;
			end
		end
		if (state_q == S_SPEED) begin
			speed_q <= speed_new;
		end
		if (state_q == S_ERR) begin
			err_q <= sat32(64'(target_q) - 64'(speed_q));
		end
		if (state_q == S_ESUM) begin
			diff_q <= 33'(err_q) - 33'(last_err_q);
		end
		if (state_q == S_ITERM) begin
			if (acc > ITERM_LIM) begin
				iterm_q <= ITERM_LIM;
			end else if (acc < -ITERM_LIM) begin
				iterm_q <= -ITERM_LIM;
			end else begin
				iterm_q <= acc;
			end
		end
		if (state_q == S_U) begin
			u_q <= iterm_q + acc;
		end
		if (load_out) begin
			spd_out_q <= speed_q;
			duty_q    <= (|u_abs[63:28]) ? 8'hff : u_abs[27:20];
			if (u_q == 64'sd0) begin
				dir_q <= DIR_STOP;
			end else if (u_q[63]) begin
				dir_q <= DIR_REV;
			end else begin
				dir_q <= DIR_FWD;
			end
		end
	end

	assign result.valid     = out_vld_q;
	assign result.duty      = duty_q;
	assign result.direction = dir_q;
	assign result.speed_rpm = spd_out_q;

`ifndef SYNTH
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == S_OUT)
		else $error("result valid rose outside the output step");

	a_stop_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.direction == DIR_STOP |-> result.duty == 8'd0)
		else $error("stop direction with nonzero duty");

	a_quot_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RAW |-> q_q <= 32'h8000_0000)
		else $error("speed quotient above cap");

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DEN && !tick.ready)
		else $error("sequencer did not start on accepted tick");
`endif

endmodule

// ===== rtl/mvp_mac.sv =====
// shared multiply-accumulate unit: 18x34 signed product, registered, then
// shifted and added into a 64-bit accumulator; uses mvp_pkg

module mvp_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mvp_pkg::mac_op_t          op,
	output logic signed [63:0]        acc
);
	import mvp_pkg::*;

	logic               vld_s1;
	logic               clr_s1;
	mac_shift_t         sh_s1;
	logic signed [51:0] prod_s1;
	logic signed [51:0] prod;
	logic signed [63:0] prod_ext;
	logic signed [63:0] addend;
	logic signed [63:0] acc_q;

	assign prod     = 52'(op.a) * 52'(op.b);
	assign prod_ext = 64'(prod_s1);

	always_comb begin
		case (sh_s1)
			SH_0:    addend = prod_ext;
			SH_17:   addend = prod_ext <<< 17;
			SH_24:   addend = prod_ext <<< 24;
			default: addend = prod_ext;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= op.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		clr_s1  <= op.clr;
		sh_s1   <= op.sh;
		if (vld_s1) begin
			acc_q <= (clr_s1 ? 64'sd0 : acc_q) + addend;
		end
	end

	assign acc = acc_q;

endmodule
